FILE: rtl/core/rmtc_pkg.sv
// shared types and constants of the cartridge mapper classifier
package rmtc_pkg;

    localparam int SCORE_W = 18;
    localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

    localparam logic [7:0]  STORE_OPCODE = 8'h32;
    localparam logic [7:0]  CHAR_A       = 8'h41;
    localparam logic [7:0]  CHAR_B       = 8'h42;
    localparam logic [63:0] SIG_NEO8     = 64'h524F_4D5F_4E45_4F38;
    localparam logic [63:0] SIG_NEO16    = 64'h524F_4D5F_4E45_3136;
    localparam int          SIG_START    = 16;
    localparam int          SIG_LEN      = 8;
    localparam int          PAGE_ONE     = 16'h4000;

    localparam logic [23:0] SIZE_MIN       = 24'd8192;
    localparam logic [23:0] SIZE_MAX_VALID = 24'd10485760;
    localparam logic [23:0] SIZE_16K       = 24'd16384;
    localparam logic [23:0] SIZE_32K       = 24'd32768;
    localparam logic [23:0] SIZE_48K       = 24'd49152;

    // bank-switch addresses seen after a store opcode
    localparam logic [15:0] ADDR_4000 = 16'h4000;
    localparam logic [15:0] ADDR_8000 = 16'h8000;
    localparam logic [15:0] ADDR_A000 = 16'hA000;
    localparam logic [15:0] ADDR_5000 = 16'h5000;
    localparam logic [15:0] ADDR_9000 = 16'h9000;
    localparam logic [15:0] ADDR_B000 = 16'hB000;
    localparam logic [15:0] ADDR_6800 = 16'h6800;
    localparam logic [15:0] ADDR_7800 = 16'h7800;
    localparam logic [15:0] ADDR_77FF = 16'h77FF;
    localparam logic [15:0] ADDR_6000 = 16'h6000;
    localparam logic [15:0] ADDR_7000 = 16'h7000;

    localparam logic [3:0] MT_UNKNOWN  = 4'd0;
    localparam logic [3:0] MT_PLAIN16K = 4'd1;
    localparam logic [3:0] MT_PLAIN32K = 4'd2;
    localparam logic [3:0] MT_SCC      = 4'd3;
    localparam logic [3:0] MT_LINEAR   = 4'd4;
    localparam logic [3:0] MT_ASCII8   = 4'd5;
    localparam logic [3:0] MT_ASCII16  = 4'd6;
    localparam logic [3:0] MT_BANK8K   = 4'd7;
    localparam logic [3:0] MT_NEO8     = 4'd8;
    localparam logic [3:0] MT_NEO16    = 4'd9;

    localparam logic PADDR_IMG_SIZE = 1'b0;

    typedef struct packed {
        logic       fire;
        logic [7:0] data;
        logic       last_flag;
    } beat_t;

    function automatic logic [7:0] sig_byte(input logic [63:0] sig, input logic [2:0] k);
        logic [2:0] idx;
        idx = 3'(3'd7 - k);
        return sig[{idx, 3'b000} +: 8];
    endfunction

endpackage

FILE: rtl/core/rom_mapper_type_classifier_top.sv
// cartridge image mapper classifier: top level with register port and beat staging
// the mapper code is registered into the result register when the beat flagged last leaves the input register
// throughput: one byte beat per cycle while byte_stall is low, set by the combinational scan and score update
// a last beat waits in the input register only while a finished code is held stalled in the result register
// reset: asynchronous active low; clears scan state, image size and both valid flags
module rom_mapper_type_classifier_top #(
    parameter int ANALYSIS_LIMIT = 131072
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  data_byte,
    input  logic        last,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [3:0]  mapper_type
);
    import rmtc_pkg::*;

    logic [23:0] img_size_reg;
    logic        in_valid_reg;
    logic [7:0]  in_data_reg;
    logic        in_last_reg;
    logic        out_valid_reg;
    logic [3:0]  out_type_reg;
    logic        res_free;
    logic        proc;
    logic [3:0]  mapper_type_next;
    beat_t       beat;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == PADDR_IMG_SIZE) ? {8'h00, img_size_reg} : 32'h0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            img_size_reg <= '0;
        else if (psel && penable && pwrite && pready && paddr[2] == PADDR_IMG_SIZE)
            img_size_reg <= pwdata[23:0];
    end

    // a last beat waits until the result register has room
    assign res_free   = !out_valid_reg || !result_stall;
    assign proc       = in_valid_reg && (!in_last_reg || res_free);
    assign byte_stall = in_valid_reg && !proc;

    assign beat = '{fire: proc, data: in_data_reg, last_flag: in_last_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!byte_stall)
            in_valid_reg <= byte_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!byte_stall && byte_valid)
        begin
            in_data_reg <= data_byte;
            in_last_reg <= last;
        end
    end

    rmtc_scan #(
        .ANALYSIS_LIMIT (ANALYSIS_LIMIT)
    ) u_scan (
        .clk              (clk),
        .rst_n            (rst_n),
        .beat             (beat),
        .img_size         (img_size_reg),
        .mapper_type_next (mapper_type_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (proc && in_last_reg)
            out_valid_reg <= 1'b1;
        else if (!result_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (proc && in_last_reg)
            out_type_reg <= mapper_type_next;
    end

    assign result_valid = out_valid_reg;
    assign mapper_type  = out_type_reg;

endmodule

FILE: rtl/core/rmtc_scan.sv
// scan state, score update and mapper decision for one byte beat
module rmtc_scan #(
    parameter int ANALYSIS_LIMIT = 131072
) (
    input  logic               clk,
    input  logic               rst_n,
    input  rmtc_pkg::beat_t    beat,
    input  logic [23:0]        img_size,
    output logic [3:0]         mapper_type_next
);
    import rmtc_pkg::*;

    localparam int PW = $clog2(ANALYSIS_LIMIT + 1);
    localparam logic [PW-1:0] LIMIT_POS = PW'(ANALYSIS_LIMIT);
    localparam logic [PW-1:0] POS_MARK0 = PW'(1);
    localparam logic [PW-1:0] POS_MARK1 = PW'(PAGE_ONE + 1);
    localparam logic [PW-1:0] POS_SIG_LO = PW'(SIG_START);
    localparam logic [PW-1:0] POS_SIG_HI = PW'(SIG_START + SIG_LEN);
    localparam logic [PW-1:0] POS_THREE = PW'(3);

    logic [23:0]        recent_reg, recent_next;
    logic [PW-1:0]      pos_reg, pos_next;
    logic               start_reg, start_next;
    logic               page1_reg, page1_next;
    logic               neo8_reg, neo8_next;
    logic               neo16_reg, neo16_next;
    logic [SCORE_W-1:0] pl_reg, pl_next;
    logic [SCORE_W-1:0] so_reg, so_next;
    logic [SCORE_W-1:0] e8_reg, e8_next;
    logic [SCORE_W-1:0] s16_reg, s16_next;

    logic               take;
    logic               store_hit;
    logic [15:0]        addr;
    logic [1:0]         w_pl, w_so, w_e8, w_s16;
    logic [SCORE_W-1:0] pl_upd, so_upd, e8_upd, s16_upd, e8_vote;
    logic               sig_full;
    logic               sz_bad;
    logic               so_win, pl_win, e8_win, s16_win;

    function automatic logic [SCORE_W-1:0] sat_add(input logic [SCORE_W-1:0] s,
                                                   input logic [1:0] w);
        logic [SCORE_W:0] sum;
        sum = {1'b0, s} + {{(SCORE_W-1){1'b0}}, w};
        return sum[SCORE_W] ? SCORE_MAX : sum[SCORE_W-1:0];
    endfunction

    assign take      = pos_reg < LIMIT_POS;
    assign addr      = {recent_reg[7:0], recent_reg[15:8]};
    assign store_hit = (pos_reg >= POS_THREE) && (recent_reg[23:16] == STORE_OPCODE);

    always_comb
    begin
        w_pl  = 2'd0;
        w_so  = 2'd0;
        w_e8  = 2'd0;
        w_s16 = 2'd0;
        if (store_hit)
        begin
            unique case (addr)
                ADDR_4000, ADDR_8000, ADDR_A000: w_pl = 2'd2;
                ADDR_5000, ADDR_9000, ADDR_B000: w_so = 2'd2;
                ADDR_6800, ADDR_7800:            w_e8 = 2'd3;
                ADDR_77FF:                       w_s16 = 2'd2;
                ADDR_6000:
                begin
                    w_pl  = 2'd2;
                    w_so  = 2'd2;
                    w_e8  = 2'd1;
                    w_s16 = 2'd2;
                end
                ADDR_7000:
                begin
                    w_so  = 2'd2;
                    w_e8  = 2'd1;
                    w_s16 = 2'd2;
                end
                default: ;
            endcase
        end
    end

    // updated state for this beat, before any clearing on last
    always_comb
    begin
        recent_next = recent_reg;
        pos_next    = pos_reg;
        start_next  = start_reg;
        page1_next  = page1_reg;
        neo8_next   = neo8_reg;
        neo16_next  = neo16_reg;
        pl_upd      = pl_reg;
        so_upd      = so_reg;
        e8_upd      = e8_reg;
        s16_upd     = s16_reg;
        if (take)
        begin
            pl_upd  = sat_add(pl_reg, w_pl);
            so_upd  = sat_add(so_reg, w_so);
            e8_upd  = sat_add(e8_reg, w_e8);
            s16_upd = sat_add(s16_reg, w_s16);
            if (pos_reg == POS_MARK0)
                start_next = (recent_reg[7:0] == CHAR_A) && (beat.data == CHAR_B);
            if (pos_reg == POS_MARK1)
                page1_next = (recent_reg[7:0] == CHAR_A) && (beat.data == CHAR_B);
            if (pos_reg >= POS_SIG_LO && pos_reg < POS_SIG_HI)
            begin
                if (beat.data != sig_byte(SIG_NEO8, pos_reg[2:0]))
                    neo8_next = 1'b0;
                if (beat.data != sig_byte(SIG_NEO16, pos_reg[2:0]))
                    neo16_next = 1'b0;
            end
            recent_next = {recent_reg[15:0], beat.data};
            pos_next    = pos_reg + 1'b1;
        end
        pl_next  = pl_upd;
        so_next  = so_upd;
        e8_next  = e8_upd;
        s16_next = s16_upd;
    end

    // decision on the updated state
    always_comb
    begin
        sig_full = pos_next >= POS_SIG_HI;
        sz_bad   = (img_size > SIZE_MAX_VALID) || (img_size < SIZE_MIN);
        e8_vote  = (e8_upd == SCORE_W'(1)) ? '0 : e8_upd;
        so_win   = (so_upd > pl_upd) && (so_upd > e8_vote) && (so_upd > s16_upd);
        pl_win   = (pl_upd > so_upd) && (pl_upd > e8_vote) && (pl_upd > s16_upd);
        e8_win   = (e8_vote > pl_upd) && (e8_vote > so_upd) && (e8_vote > s16_upd);
        s16_win  = (s16_upd > pl_upd) && (s16_upd > so_upd) && (s16_upd > e8_vote);
        priority if (sz_bad)
            mapper_type_next = MT_UNKNOWN;
        else if (start_next && img_size == SIZE_16K)
            mapper_type_next = MT_PLAIN16K;
        else if (start_next && img_size <= SIZE_32K)
            mapper_type_next = page1_next ? MT_LINEAR : MT_PLAIN32K;
        else if (start_next && sig_full && neo8_next)
            mapper_type_next = MT_NEO8;
        else if (start_next && sig_full && neo16_next)
            mapper_type_next = MT_NEO16;
        else if (page1_next && img_size == SIZE_48K)
            mapper_type_next = MT_LINEAR;
        else if (img_size <= SIZE_32K)
            mapper_type_next = MT_UNKNOWN;
        else if (so_win)
            mapper_type_next = MT_SCC;
        else if (pl_win)
            mapper_type_next = MT_BANK8K;
        else if (e8_win)
            mapper_type_next = MT_ASCII8;
        else if (s16_win || s16_upd == so_upd)
            mapper_type_next = MT_ASCII16;
        else
            mapper_type_next = MT_UNKNOWN;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recent_reg <= '0;
            pos_reg    <= '0;
            start_reg  <= 1'b0;
            page1_reg  <= 1'b0;
            neo8_reg   <= 1'b1;
            neo16_reg  <= 1'b1;
            pl_reg     <= '0;
            so_reg     <= '0;
            e8_reg     <= '0;
            s16_reg    <= '0;
        end
        else if (beat.fire)
        begin
            if (beat.last_flag)
            begin
                // image done, back to a clean scan
                recent_reg <= '0;
                pos_reg    <= '0;
                start_reg  <= 1'b0;
                page1_reg  <= 1'b0;
                neo8_reg   <= 1'b1;
                neo16_reg  <= 1'b1;
                pl_reg     <= '0;
                so_reg     <= '0;
                e8_reg     <= '0;
                s16_reg    <= '0;
            end
            else
            begin
                recent_reg <= recent_next;
                pos_reg    <= pos_next;
                start_reg  <= start_next;
                page1_reg  <= page1_next;
                neo8_reg   <= neo8_next;
                neo16_reg  <= neo16_next;
                pl_reg     <= pl_next;
                so_reg     <= so_next;
                e8_reg     <= e8_next;
                s16_reg    <= s16_next;
            end
        end
    end

endmodule

FILE: verif/rom_mapper_type_classifier_top_tb.sv
// self-checking testbench for the cartridge mapper classifier top level
`timescale 1ns / 1ps

module rom_mapper_type_classifier_top_tb;
    import rmtc_pkg::*;

    localparam int WINDOW_LIMIT = 131072;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int NO_CODE = -1;
    localparam int HOLD_CYCLES = 300;
    localparam int PLAN_ROWS = 22;
    // register 0 sits at byte address 0
    localparam logic [2:0] IMG_SIZE_ADDR = 3'd0;

    localparam logic [15:0] STORE_ADDRS [11] = '{
        ADDR_4000, ADDR_8000, ADDR_A000, ADDR_5000, ADDR_9000, ADDR_B000,
        ADDR_6800, ADDR_7800, ADDR_77FF, ADDR_6000, ADDR_7000
    };

    typedef enum int {
        IMG_NOISE, IMG_START, IMG_PAGE1, IMG_BOTH, IMG_NEO8, IMG_NEO16, IMG_SIG_BAD, IMG_TAIL
    } img_kind_t;

    typedef enum int {
        FAVOR_PLAIN, FAVOR_SOUND, FAVOR_EIGHT_K, FAVOR_SIXTEEN_K, FAVOR_MIX, FAVOR_NONE
    } favor_t;

    typedef struct {
        logic [23:0] size;
        img_kind_t   kind;
        favor_t      favor;
        int          len;
        int          code;
    } image_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        byte_valid = 1'b0;
    logic        byte_stall;
    logic [7:0]  data_byte = '0;
    logic        last = 1'b0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [3:0]  mapper_type;

    // expected mapper codes, oldest first
    logic [3:0]  pending_codes [$];
    logic [7:0]  rom_bytes [$];
    int          beat_code = NO_CODE;
    int          cycles = 0;
    int          fails = 0;
    int          bytes_sent = 0;
    bit          calm = 1'b0;
    bit          hold_req = 1'b0;
    bit          hold_done = 1'b0;
    logic [3:0]  want_code;

    // predictor state
    logic [23:0] cfg_size = '0;
    logic [23:0] hist;
    int          scan_pos;
    logic        ab_start, ab_page1, neo8_ok, neo16_ok;
    logic [SCORE_W-1:0] plain_sc, sound_sc, e8_sc, s16_sc;

    image_row_t plan [PLAN_ROWS] = '{
        '{24'd0,                  IMG_NOISE,   FAVOR_MIX,       10,           MT_UNKNOWN},
        '{SIZE_MIN - 24'd1,       IMG_START,   FAVOR_NONE,      4,            MT_UNKNOWN},
        '{24'hFFFFFF,             IMG_NEO8,    FAVOR_NONE,      24,           MT_UNKNOWN},
        '{SIZE_MAX_VALID + 24'd1, IMG_START,   FAVOR_PLAIN,     40,           MT_UNKNOWN},
        '{SIZE_16K,               IMG_START,   FAVOR_NONE,      2,            MT_PLAIN16K},
        '{SIZE_MIN,               IMG_START,   FAVOR_SOUND,     3,            MT_PLAIN32K},
        '{SIZE_32K,               IMG_START,   FAVOR_NONE,      1,            MT_UNKNOWN},
        '{SIZE_MAX_VALID,         IMG_NEO8,    FAVOR_MIX,       24,           MT_NEO8},
        '{SIZE_32K + 24'd1,       IMG_NEO16,   FAVOR_EIGHT_K,   30,           MT_NEO16},
        '{24'd65536,              IMG_NEO8,    FAVOR_NONE,      20,           NO_CODE},
        '{24'd65536,              IMG_SIG_BAD, FAVOR_SOUND,     32,           NO_CODE},
        '{SIZE_48K,               IMG_PAGE1,   FAVOR_NONE,      PAGE_ONE + 2, MT_LINEAR},
        '{SIZE_32K,               IMG_BOTH,    FAVOR_MIX,       PAGE_ONE + 2, MT_LINEAR},
        '{SIZE_48K,               IMG_PAGE1,   FAVOR_NONE,      PAGE_ONE + 1, NO_CODE},
        '{24'd1048576,            IMG_NOISE,   FAVOR_SOUND,     120,          NO_CODE},
        '{24'd98304,              IMG_NOISE,   FAVOR_PLAIN,     120,          NO_CODE},
        '{24'd131072,             IMG_START,   FAVOR_EIGHT_K,   120,          NO_CODE},
        '{24'd262144,             IMG_NOISE,   FAVOR_SIXTEEN_K, 120,          NO_CODE},
        '{24'd65536,              IMG_NOISE,   FAVOR_NONE,      1,            MT_ASCII16},
        '{24'd65536,              IMG_TAIL,    FAVOR_NONE,      3,            MT_ASCII16},
        '{24'd65536,              IMG_TAIL,    FAVOR_NONE,      4,            MT_SCC},
        '{24'd1048576,            IMG_START,   FAVOR_MIX,       WINDOW_LIMIT + 5, NO_CODE}
    };

    rom_mapper_type_classifier_top #(
        .ANALYSIS_LIMIT(WINDOW_LIMIT)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .byte_valid(byte_valid),
        .byte_stall(byte_stall),
        .data_byte(data_byte),
        .last(last),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .mapper_type(mapper_type)
    );

    always #10 clk = ~clk;

    function automatic logic [SCORE_W-1:0] sat_add(input logic [SCORE_W-1:0] s, input int w);
        int sum;
        sum = int'(s) + w;
        return (sum > int'(SCORE_MAX)) ? SCORE_MAX : SCORE_W'(sum);
    endfunction

    function automatic void scan_clear();
        hist = '0;
        scan_pos = 0;
        ab_start = 1'b0;
        ab_page1 = 1'b0;
        neo8_ok = 1'b1;
        neo16_ok = 1'b1;
        plain_sc = '0;
        sound_sc = '0;
        e8_sc = '0;
        s16_sc = '0;
    endfunction

    function automatic void weigh_store(input logic [15:0] addr);
        case (addr)
            ADDR_4000, ADDR_8000, ADDR_A000: plain_sc = sat_add(plain_sc, 2);
            ADDR_5000, ADDR_9000, ADDR_B000: sound_sc = sat_add(sound_sc, 2);
            ADDR_6800, ADDR_7800:            e8_sc = sat_add(e8_sc, 3);
            ADDR_77FF:                       s16_sc = sat_add(s16_sc, 2);
            ADDR_6000:
            begin
                plain_sc = sat_add(plain_sc, 2);
                sound_sc = sat_add(sound_sc, 2);
                e8_sc = sat_add(e8_sc, 1);
                s16_sc = sat_add(s16_sc, 2);
            end
            ADDR_7000:
            begin
                sound_sc = sat_add(sound_sc, 2);
                e8_sc = sat_add(e8_sc, 1);
                s16_sc = sat_add(s16_sc, 2);
            end
            default: ;
        endcase
    endfunction

    function automatic void scan_byte(input logic [7:0] b);
        int k;
        // opcode three beats back, address low byte then high byte
        if (scan_pos >= 3 && hist[23:16] == STORE_OPCODE)
            weigh_store({hist[7:0], hist[15:8]});
        if (scan_pos == 1)
            ab_start = (hist[7:0] == CHAR_A && b == CHAR_B);
        if (scan_pos == PAGE_ONE + 1)
            ab_page1 = (hist[7:0] == CHAR_A && b == CHAR_B);
        if (scan_pos >= SIG_START && scan_pos < SIG_START + SIG_LEN)
        begin
            k = scan_pos - SIG_START;
            if (b != SIG_NEO8[63 - 8*k -: 8])
                neo8_ok = 1'b0;
            if (b != SIG_NEO16[63 - 8*k -: 8])
                neo16_ok = 1'b0;
        end
        hist = {hist[15:0], b};
        scan_pos++;
    endfunction

    function automatic logic [3:0] mapper_verdict();
        logic sig_full;
        logic [SCORE_W-1:0] pl, so, e8, s16;
        sig_full = scan_pos >= SIG_START + SIG_LEN;
        pl = plain_sc;
        so = sound_sc;
        e8 = e8_sc;
        s16 = s16_sc;
        if (cfg_size > SIZE_MAX_VALID || cfg_size < SIZE_MIN)
            return MT_UNKNOWN;
        if (ab_start && cfg_size == SIZE_16K)
            return MT_PLAIN16K;
        if (ab_start && cfg_size <= SIZE_32K)
            return ab_page1 ? MT_LINEAR : MT_PLAIN32K;
        if (ab_start && sig_full && neo8_ok)
            return MT_NEO8;
        if (ab_start && sig_full && neo16_ok)
            return MT_NEO16;
        if (ab_page1 && cfg_size == SIZE_48K)
            return MT_LINEAR;
        if (cfg_size <= SIZE_32K)
            return MT_UNKNOWN;
        // a lone shared-address hit does not count for the ASCII8 mapper
        if (e8 == 1)
            e8 = '0;
        if (so > pl && so > e8 && so > s16)
            return MT_SCC;
        if (pl > so && pl > e8 && pl > s16)
            return MT_BANK8K;
        if (e8 > pl && e8 > so && e8 > s16)
            return MT_ASCII8;
        if (s16 > pl && s16 > so && s16 > e8)
            return MT_ASCII16;
        if (s16 == so)
            return MT_ASCII16;
        return MT_UNKNOWN;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        fails++;
        $display("mismatch at cycle %0d: %s, got %0d, want %0d", cycles, what, got, want);
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout with %0d codes outstanding", pending_codes.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // beat acceptance feeds the predictor, then the result side is checked
    always @(posedge clk)
    begin
        if (byte_valid && !byte_stall)
        begin
            if (scan_pos < WINDOW_LIMIT)
                scan_byte(data_byte);
            if (last)
            begin
                pending_codes.push_back(beat_code >= 0 ? 4'(beat_code) : mapper_verdict());
                scan_clear();
            end
        end
        if (result_valid && !result_stall)
        begin
            if (pending_codes.size() == 0)
                report_mismatch("mapper code with none expected", mapper_type, 0);
            else
            begin
                want_code = pending_codes.pop_front();
                if (mapper_type !== want_code)
                    report_mismatch("mapper_type", mapper_type, want_code);
            end
        end
    end

    // result side: short random stalls, one long hold-off
    initial
    begin
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
                result_stall <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(negedge clk);
                result_stall <= 1'b0;
            end
            else
                result_stall <= 1'b0;
        end
    end

    function automatic logic [15:0] pick_addr(input favor_t favor);
        int r;
        r = $urandom_range(0, 9);
        if (r == 9)
            return 16'($urandom);
        if (r >= 6 || favor == FAVOR_MIX)
            return STORE_ADDRS[$urandom_range(0, 10)];
        case (favor)
            FAVOR_PLAIN:   return STORE_ADDRS[$urandom_range(0, 2)];
            FAVOR_SOUND:   return STORE_ADDRS[$urandom_range(3, 5)];
            FAVOR_EIGHT_K: return STORE_ADDRS[$urandom_range(6, 7)];
            default:       return ADDR_77FF;
        endcase
    endfunction

    function automatic void put_byte(input int at, input logic [7:0] b);
        if (at < rom_bytes.size())
            rom_bytes[at] = b;
    endfunction

    function automatic void build_image(input img_kind_t kind, input favor_t favor, input int len);
        logic [15:0] a;
        logic [63:0] sig;
        int k;
        rom_bytes.delete();
        while (rom_bytes.size() < len)
        begin
            if (favor != FAVOR_NONE && $urandom_range(0, 2) == 0)
            begin
                a = pick_addr(favor);
                rom_bytes.push_back(STORE_OPCODE);
                rom_bytes.push_back(a[7:0]);
                rom_bytes.push_back(a[15:8]);
            end
            else if ($urandom_range(0, 15) == 0)
                rom_bytes.push_back(STORE_OPCODE);
            else
                rom_bytes.push_back(8'($urandom));
        end
        while (rom_bytes.size() > len)
            void'(rom_bytes.pop_back());
        if (kind inside {IMG_START, IMG_BOTH, IMG_NEO8, IMG_NEO16, IMG_SIG_BAD})
        begin
            put_byte(0, CHAR_A);
            put_byte(1, CHAR_B);
        end
        if (kind inside {IMG_PAGE1, IMG_BOTH})
        begin
            put_byte(PAGE_ONE, CHAR_A);
            put_byte(PAGE_ONE + 1, CHAR_B);
        end
        if (kind inside {IMG_NEO8, IMG_NEO16, IMG_SIG_BAD})
        begin
            sig = (kind == IMG_NEO16 || (kind == IMG_SIG_BAD && $urandom_range(0, 1) == 1))
                ? SIG_NEO16 : SIG_NEO8;
            // one flipped bit somewhere in the signature
            if (kind == IMG_SIG_BAD)
                sig[$urandom_range(0, 63)] ^= 1'b1;
            for (k = 0; k < SIG_LEN; k++)
                put_byte(SIG_START + k, sig[63 - 8*k -: 8]);
        end
        if (kind == IMG_TAIL)
        begin
            put_byte(0, STORE_OPCODE);
            put_byte(1, ADDR_5000[7:0]);
            put_byte(2, ADDR_5000[15:8]);
        end
    endfunction

    task automatic send_beat(input logic [7:0] b, input logic is_last, input int code);
        @(negedge clk);
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            byte_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        byte_valid <= 1'b1;
        data_byte <= b;
        last <= is_last;
        beat_code <= code;
        do
            @(posedge clk);
        while (byte_stall);
    endtask

    task automatic send_image(input img_kind_t kind, input favor_t favor, input int len,
                              input int code);
        build_image(kind, favor, len);
        foreach (rom_bytes[i])
            send_beat(rom_bytes[i], i == rom_bytes.size() - 1, code);
    endtask

    // drop valid and wait for every outstanding code plus the pipeline tail
    task automatic settle();
        @(negedge clk);
        byte_valid <= 1'b0;
        while (pending_codes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_img_size(input logic [23:0] size);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= IMG_SIZE_ADDR;
        pwdata <= {8'h00, size};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cfg_size = size;
    endtask

    function automatic logic [23:0] pick_size();
        case ($urandom_range(0, 13))
            0:       return 24'd0;
            1:       return SIZE_MIN - 24'd1;
            2:       return SIZE_MIN;
            3:       return SIZE_16K;
            4:       return SIZE_32K;
            5:       return SIZE_32K + 24'd1;
            6:       return SIZE_48K;
            7:       return SIZE_MAX_VALID;
            8:       return SIZE_MAX_VALID + 24'd1;
            9:       return 24'hFFFFFF;
            default: return 24'($urandom_range(SIZE_32K + 1, SIZE_MAX_VALID));
        endcase
    endfunction

    initial
    begin
        img_kind_t kind;
        favor_t favor;
        int len;
        int images;
        scan_clear();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[r])
        begin
            settle();
            write_img_size(plan[r].size);
            send_image(plan[r].kind, plan[r].favor, plan[r].len, plan[r].code);
        end

        // tiny images back to back while the result side holds off
        settle();
        write_img_size(SIZE_32K + 24'd1);
        hold_req = 1'b1;
        repeat (60)
            send_image(img_kind_t'($urandom_range(0, 7)), favor_t'($urandom_range(0, 5)),
                       $urandom_range(1, 6), NO_CODE);
        settle();

        images = 0;
        while (bytes_sent < 2000 || images < 60)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                settle();
                write_img_size(pick_size());
            end
            calm = bytes_sent >= 1700;
            kind = img_kind_t'($urandom_range(0, 7));
            favor = favor_t'($urandom_range(0, 5));
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(65, 400) : $urandom_range(1, 64);
            send_image(kind, favor, len, NO_CODE);
            bytes_sent += len;
            images++;
        end

        settle();
        repeat (8) @(posedge clk);
        if (fails == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/rmtc_pkg.sv
rtl/core/rmtc_scan.sv
rtl/core/rom_mapper_type_classifier_top.sv
verif/rom_mapper_type_classifier_top_tb.sv
